FILE: hw/rtl/lsm_pkg.sv
// Shared constants, codes and types of the latency statistics monitor.
`default_nettype none

package lsm_pkg;

  localparam int TIME_W    = 32;
  localparam int COUNT_W   = 16;
  localparam int RATIO_W   = 16;
  localparam int STEP_W    = $clog2(TIME_W + 1);
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [1:0] MODE_START   = 2'd0;
  localparam logic [1:0] MODE_STOP    = 2'd1;
  localparam logic [1:0] MODE_RESTART = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_COUNT   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RESET_EXTREMES = 2'd1;

  localparam logic [COUNT_W-1:0] SAMPLE_COUNT_RESET = COUNT_W'(100);
  localparam logic [TIME_W-1:0]  MIN_RESET_VALUE    = TIME_W'(100000);
  localparam logic [TIME_W-1:0]  MIN_REPORT_RESET   = TIME_W'(10000000);
  localparam logic [RATIO_W-1:0] RATIO_MAX          = {RATIO_W{1'b1}};

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHK,
    ST_FRAC,
    ST_DIV,
    ST_UPD,
    ST_FIN
  } state_t;

endpackage

`default_nettype wire

FILE: hw/rtl/latency_stats_monitor_core.sv
// Top level of the latency statistics monitor: sequencer, state and report register.
//
//  channel | ports                                   | direction | flow control
//  --------+-----------------------------------------+-----------+-------------
//  in      | in_mode, in_timestamp                   | into core | valid/stall
//  out     | out_report_valid .. out_busy_ratio      | from core | valid/stall
//  cfg     | cfg_index, cfg_data                     | into core | valid/ready
//
// Start marks, mode three and stops that add to the window are handled without
// leaving idle. A report stop passes through its accept, a check state, 16 ratio
// steps (skipped when the ratio saturates), 32 division steps, an update state and
// a final state that hands the word to the output register. A report on an empty
// window goes straight to the final state. The hand-off waits while the output
// register still holds an unaccepted word. Reset is synchronous; the output
// register holds a finished word while the next input word is already taken.
`default_nettype none

module latency_stats_monitor_core (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [1:0]                        in_mode,
  input  logic [31:0]                       in_timestamp,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic                              out_report_valid,
  output logic [31:0]                       out_average_time,
  output logic [31:0]                       out_min_time,
  output logic [31:0]                       out_max_time,
  output logic [15:0]                       out_busy_ratio,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [lsm_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [lsm_pkg::CFG_DATA_W-1:0]    cfg_data
);

  lsm_pkg::state_t state_r, state_nxt;

  logic [lsm_pkg::COUNT_W-1:0] sample_count_r, sample_count_nxt;
  logic                        reset_ext_r, reset_ext_nxt;

  logic [lsm_pkg::TIME_W-1:0]  start_r, start_nxt;
  logic [lsm_pkg::TIME_W-1:0]  origin_r, origin_nxt;
  logic [lsm_pkg::TIME_W-1:0]  total_r, total_nxt;
  logic [lsm_pkg::COUNT_W-1:0] counter_r, counter_nxt;
  logic [lsm_pkg::TIME_W-1:0]  avg_r, avg_nxt;
  logic [lsm_pkg::TIME_W-1:0]  min_r, min_nxt;
  logic [lsm_pkg::TIME_W-1:0]  max_r, max_nxt;
  logic [lsm_pkg::RATIO_W-1:0] ratio_r, ratio_nxt;

  logic [lsm_pkg::TIME_W-1:0]  acc_r, acc_nxt;
  logic [lsm_pkg::TIME_W-1:0]  quo_r, quo_nxt;
  logic [lsm_pkg::TIME_W-1:0]  gap_r, gap_nxt;
  logic [lsm_pkg::TIME_W-1:0]  now_r, now_nxt;
  logic [lsm_pkg::STEP_W-1:0]  step_r, step_nxt;

  logic                        out_valid_r, out_valid_nxt;
  logic [31:0]                 out_avg_r, out_avg_nxt;
  logic [31:0]                 out_min_r, out_min_nxt;
  logic [31:0]                 out_max_r, out_max_nxt;
  logic [15:0]                 out_ratio_r, out_ratio_nxt;

  logic                        in_fire;
  logic                        is_stop;
  logic                        add_ok;
  logic                        step_last;
  logic                        out_free;
  logic                        shift_in;
  logic [lsm_pkg::TIME_W:0]    unit_a;
  logic [lsm_pkg::TIME_W-1:0]  unit_b;
  logic                        unit_ge;
  logic [lsm_pkg::TIME_W-1:0]  unit_res;

  assign in_fire   = in_valid && !in_stall;
  assign in_stall  = (state_r != lsm_pkg::ST_IDLE);
  assign is_stop   = (in_mode == lsm_pkg::MODE_STOP) || (in_mode == lsm_pkg::MODE_RESTART);
  assign add_ok    = (counter_r < sample_count_r);
  assign step_last = (step_r == lsm_pkg::STEP_W'(1));
  assign out_free  = !out_valid_r || !out_stall;
  assign cfg_ready = 1'b1;

  // The ratio loop shifts in zeros; the division shifts in the dividend bits.
  assign shift_in = (state_r == lsm_pkg::ST_DIV) ? quo_r[lsm_pkg::TIME_W-1] : 1'b0;
  assign unit_a   = (state_r == lsm_pkg::ST_CHK) ? {1'b0, total_r} : {acc_r, shift_in};
  assign unit_b   = (state_r == lsm_pkg::ST_DIV) ?
                    {{(lsm_pkg::TIME_W - lsm_pkg::COUNT_W){1'b0}}, counter_r} : gap_r;

  lsm_sub_unit u_sub (
    .op_a (unit_a),
    .op_b (unit_b),
    .ge   (unit_ge),
    .res  (unit_res)
  );

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      lsm_pkg::ST_IDLE: begin
        if (in_fire && is_stop && !add_ok) begin
          state_nxt = (counter_r == '0) ? lsm_pkg::ST_FIN : lsm_pkg::ST_CHK;
        end
      end
      lsm_pkg::ST_CHK: begin
        state_nxt = unit_ge ? lsm_pkg::ST_DIV : lsm_pkg::ST_FRAC;
      end
      lsm_pkg::ST_FRAC: begin
        if (step_last) begin
          state_nxt = lsm_pkg::ST_DIV;
        end
      end
      lsm_pkg::ST_DIV: begin
        if (step_last) begin
          state_nxt = lsm_pkg::ST_UPD;
        end
      end
      lsm_pkg::ST_UPD: begin
        state_nxt = lsm_pkg::ST_FIN;
      end
      lsm_pkg::ST_FIN: begin
        if (out_free) begin
          state_nxt = lsm_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = lsm_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    sample_count_nxt = sample_count_r;
    reset_ext_nxt    = reset_ext_r;
    start_nxt        = start_r;
    origin_nxt       = origin_r;
    total_nxt        = total_r;
    counter_nxt      = counter_r;
    avg_nxt          = avg_r;
    min_nxt          = min_r;
    max_nxt          = max_r;
    ratio_nxt        = ratio_r;
    acc_nxt          = acc_r;
    quo_nxt          = quo_r;
    gap_nxt          = gap_r;
    now_nxt          = now_r;
    step_nxt         = step_r;
    out_valid_nxt    = out_valid_r && out_stall;
    out_avg_nxt      = out_avg_r;
    out_min_nxt      = out_min_r;
    out_max_nxt      = out_max_r;
    out_ratio_nxt    = out_ratio_r;

    if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        lsm_pkg::CFG_SAMPLE_COUNT:   sample_count_nxt = cfg_data[lsm_pkg::COUNT_W-1:0];
        lsm_pkg::CFG_RESET_EXTREMES: reset_ext_nxt    = cfg_data[0];
        default: ;
      endcase
    end

    case (state_r)
      lsm_pkg::ST_IDLE: begin
        if (in_fire) begin
          if (is_stop) begin
            if (add_ok) begin
              total_nxt   = total_r + (in_timestamp - start_r);
              counter_nxt = counter_r + lsm_pkg::COUNT_W'(1);
            end else begin
              now_nxt = in_timestamp;
              gap_nxt = in_timestamp - origin_r;
            end
          end
          // A restart stamps the new start after its stop has been handled.
          if ((in_mode == lsm_pkg::MODE_START) || (in_mode == lsm_pkg::MODE_RESTART)) begin
            start_nxt = in_timestamp;
          end
        end
      end
      lsm_pkg::ST_CHK: begin
        // Total at least the elapsed time, or no time elapsed: the ratio saturates.
        if (unit_ge) begin
          ratio_nxt = lsm_pkg::RATIO_MAX;
          acc_nxt   = '0;
          quo_nxt   = total_r;
          step_nxt  = lsm_pkg::STEP_W'(lsm_pkg::TIME_W);
        end else begin
          acc_nxt  = total_r;
          step_nxt = lsm_pkg::STEP_W'(lsm_pkg::RATIO_W);
        end
      end
      lsm_pkg::ST_FRAC: begin
        if (step_last) begin
          ratio_nxt = {quo_r[lsm_pkg::RATIO_W-2:0], unit_ge};
          acc_nxt   = '0;
          quo_nxt   = total_r;
          step_nxt  = lsm_pkg::STEP_W'(lsm_pkg::TIME_W);
        end else begin
          acc_nxt  = unit_res;
          quo_nxt  = {quo_r[lsm_pkg::TIME_W-2:0], unit_ge};
          step_nxt = step_r - lsm_pkg::STEP_W'(1);
        end
      end
      lsm_pkg::ST_DIV: begin
        acc_nxt  = unit_res;
        quo_nxt  = {quo_r[lsm_pkg::TIME_W-2:0], unit_ge};
        step_nxt = step_r - lsm_pkg::STEP_W'(1);
      end
      lsm_pkg::ST_UPD: begin
        avg_nxt = quo_r;
        if (quo_r > max_r) begin
          max_nxt = quo_r;
        end
        if (quo_r < min_r) begin
          min_nxt = quo_r;
        end
        origin_nxt  = now_r;
        counter_nxt = '0;
        total_nxt   = '0;
      end
      lsm_pkg::ST_FIN: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_avg_nxt   = avg_r;
          out_min_nxt   = min_r;
          out_max_nxt   = max_r;
          out_ratio_nxt = ratio_r;
          // The report carries the extremes as they stood before this reset.
          if (reset_ext_r) begin
            min_nxt = lsm_pkg::MIN_REPORT_RESET;
            max_nxt = '0;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= lsm_pkg::ST_IDLE;
      sample_count_r <= lsm_pkg::SAMPLE_COUNT_RESET;
      reset_ext_r    <= 1'b0;
      start_r        <= '0;
      origin_r       <= '0;
      total_r        <= '0;
      counter_r      <= '0;
      avg_r          <= '0;
      min_r          <= lsm_pkg::MIN_RESET_VALUE;
      max_r          <= '0;
      ratio_r        <= '0;
      out_valid_r    <= 1'b0;
    end else begin
      state_r        <= state_nxt;
      sample_count_r <= sample_count_nxt;
      reset_ext_r    <= reset_ext_nxt;
      start_r        <= start_nxt;
      origin_r       <= origin_nxt;
      total_r        <= total_nxt;
      counter_r      <= counter_nxt;
      avg_r          <= avg_nxt;
      min_r          <= min_nxt;
      max_r          <= max_nxt;
      ratio_r        <= ratio_nxt;
      out_valid_r    <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_r       <= acc_nxt;
    quo_r       <= quo_nxt;
    gap_r       <= gap_nxt;
    now_r       <= now_nxt;
    step_r      <= step_nxt;
    out_avg_r   <= out_avg_nxt;
    out_min_r   <= out_min_nxt;
    out_max_r   <= out_max_nxt;
    out_ratio_r <= out_ratio_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_report_valid = 1'b1;
  assign out_average_time = out_avg_r;
  assign out_min_time     = out_min_r;
  assign out_max_time     = out_max_r;
  assign out_busy_ratio   = out_ratio_r;

endmodule

`default_nettype wire

FILE: hw/rtl/lsm_sub_unit.sv
// Shared compare and conditional subtract step used by the divider and the ratio loop.
`default_nettype none

module lsm_sub_unit (
  input  logic [lsm_pkg::TIME_W:0]   op_a,
  input  logic [lsm_pkg::TIME_W-1:0] op_b,
  output logic                       ge,
  output logic [lsm_pkg::TIME_W-1:0] res
);

  logic [lsm_pkg::TIME_W+1:0] diff;

  assign diff = {1'b0, op_a} - {2'b00, op_b};
  assign ge   = ~diff[lsm_pkg::TIME_W+1];
  // The callers guarantee the kept value fits back into TIME_W bits.
  assign res  = ge ? diff[lsm_pkg::TIME_W-1:0] : op_a[lsm_pkg::TIME_W-1:0];

endmodule

`default_nettype wire
